// File: hw/rtl/slnl_pkg.sv
// Package for the sound and light night lamp controller.
// Holds event and register codes, sizing constants and the per-second averaging divider.
// No dependencies.
package slnl_pkg;

  // Fixed field widths
  localparam int unsigned OPCODE_W     = 2;
  localparam int unsigned SAMPLE_BITS  = 14;
  localparam int unsigned LUX_W        = 17;
  localparam int unsigned ON_TICKS_W   = 16;
  localparam int unsigned RISE_W       = 7;
  localparam int unsigned CFG_IDX_W    = 2;
  localparam int unsigned CFG_DATA_W   = 17;

  // Averaging window and baseline depth
  localparam int unsigned SAMPLES_PER_SECOND = 100;
  localparam int unsigned BASELINE_SECONDS   = 5;

  localparam int unsigned SUM_W     = $clog2(SAMPLES_PER_SECOND * (2 ** SAMPLE_BITS));
  localparam int unsigned SCNT_W    = $clog2(SAMPLES_PER_SECOND);
  localparam int unsigned BIDX_W    = (BASELINE_SECONDS > 1) ? $clog2(BASELINE_SECONDS) : 1;

  // Truncating divide by SAMPLES_PER_SECOND as a multiply by a rounded-up reciprocal.
  // The rounding error stays below one count over the whole sum range.
  localparam int unsigned DIV_SHIFT = SUM_W + $clog2(SAMPLES_PER_SECOND);
  localparam int unsigned MULT_W    = SUM_W + 1;
  localparam longint unsigned DIV_MULT =
    ((64'd1 << DIV_SHIFT) + SAMPLES_PER_SECOND - 1) / SAMPLES_PER_SECOND;

  // Rise test: 100 * avg > baseline * (100 + rise_percent)
  localparam int unsigned PCT_SCALE = 100;
  localparam int unsigned FACTOR_W  = RISE_W + 1;
  localparam int unsigned RHS_W     = SAMPLE_BITS + FACTOR_W;

  // Reset values of the configuration registers
  localparam logic [LUX_W-1:0]      DARK_THRESHOLD_RST = LUX_W'(30);
  localparam logic [ON_TICKS_W-1:0] ON_TICKS_RST       = ON_TICKS_W'(1000);
  localparam logic [RISE_W-1:0]     RISE_PERCENT_RST   = RISE_W'(5);

  typedef enum logic [OPCODE_W-1:0] {
    OP_MIC    = 2'd0,
    OP_LUX    = 2'd1,
    OP_TICK   = 2'd2,
    OP_BUTTON = 2'd3
  } opcode_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_DARK_THRESHOLD = 2'd0,
    CFG_ON_TICKS       = 2'd1,
    CFG_RISE_PERCENT   = 2'd2,
    CFG_UNUSED         = 2'd3
  } cfg_idx_e;

  function automatic logic [SAMPLE_BITS-1:0] sps_div(input logic [SUM_W-1:0] sum);
    logic [SUM_W+MULT_W-1:0] prod;
    prod = {{MULT_W{1'b0}}, sum} * (SUM_W + MULT_W)'(DIV_MULT);
    return prod[DIV_SHIFT +: SAMPLE_BITS];
  endfunction

endpackage

// File: hw/rtl/sound_light_night_lamp_controller.sv
// Top level of the sound and light night lamp controller.
// Depends on slnl_pkg for codes, widths and the per-second divider.
//
// Usage:
//  - Input channel (in_valid_i / in_ready_o) carries one event item: a mic sample,
//    a lux reading, a lamp tick or a button press, selected by opcode_i.
//  - Output channel (out_valid_o / out_ready_i) returns exactly one result item per
//    event: lamp drive, night mode, sound flag and monitoring phase after that event.
//  - Configuration is a plain write port (cfg_we_i, cfg_idx_i, cfg_data_i); write
//    only while no item is in flight. Index 3 is ignored.
// Timing:
//  - An accepted item is held in the input register and its result is loaded into the
//    result register when the result slot is free or being emptied; out_valid_o rises
//    with that load.
//  - Throughput is one item per cycle while out_ready_i is high. All state, including the end-of-second
//    average and rise test, updates in a single pass between the input register
//    and the result register.
// Reset: controller state and valid flags clear, baseline collection restarts, lamp off,
//  registers take their defaults (dark 30 lux, 1000 ticks, 5 percent).
// Stall: while out_ready_i is low the result register holds; the input register
//  still accepts one more item, then in_ready_o drops until the result moves on.
module sound_light_night_lamp_controller
  import slnl_pkg::*;
(
  input  logic                    clk_i,
  input  logic                    rst_ni,

  input  logic                    cfg_we_i,
  input  logic [CFG_IDX_W-1:0]    cfg_idx_i,
  input  logic [CFG_DATA_W-1:0]   cfg_data_i,

  input  logic                    in_valid_i,
  output logic                    in_ready_o,
  input  logic [OPCODE_W-1:0]     opcode_i,
  input  logic [SAMPLE_BITS-1:0]  mic_sample_i,
  input  logic [LUX_W-1:0]        lux_value_i,

  output logic                    out_valid_o,
  input  logic                    out_ready_i,
  output logic                    lamp_on_o,
  output logic                    night_active_o,
  output logic                    sound_seen_o,
  output logic                    monitoring_o
);

  // Configuration registers
  logic [LUX_W-1:0]      dark_thr_q;
  logic [ON_TICKS_W-1:0] on_ticks_q;
  logic [RISE_W-1:0]     rise_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dark_thr_q <= DARK_THRESHOLD_RST;
      on_ticks_q <= ON_TICKS_RST;
      rise_q     <= RISE_PERCENT_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_e'(cfg_idx_i))
        CFG_DARK_THRESHOLD: dark_thr_q <= cfg_data_i[LUX_W-1:0];
        CFG_ON_TICKS:       on_ticks_q <= cfg_data_i[ON_TICKS_W-1:0];
        CFG_RISE_PERCENT:   rise_q     <= cfg_data_i[RISE_W-1:0];
        default: ;
      endcase
    end
  end

  // Rise setting as it stands after this edge
  logic [RISE_W-1:0]     rise_d;

  assign rise_d = (cfg_we_i && (cfg_idx_e'(cfg_idx_i) == CFG_RISE_PERCENT)) ?
                  cfg_data_i[RISE_W-1:0] : rise_q;

  // Input register and handshake
  logic                   in_valid_q;
  opcode_e                op_q;
  logic [SAMPLE_BITS-1:0] mic_q;
  logic [LUX_W-1:0]       lux_q;
  logic                   out_valid_q;
  logic                   advance;

  // Process the held item whenever the result slot is free or being emptied
  assign advance    = in_valid_q && (!out_valid_q || out_ready_i);
  assign in_ready_o = !in_valid_q || advance;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_ready_o) begin
      in_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      op_q  <= opcode_e'(opcode_i);
      mic_q <= mic_sample_i;
      lux_q <= lux_value_i;
    end
  end

  // Controller state
  logic [SUM_W-1:0]       sum_q,      sum_d;
  logic [SCNT_W-1:0]      scnt_q,     scnt_d;
  logic [SAMPLE_BITS-1:0] base_q [BASELINE_SECONDS];
  logic [SAMPLE_BITS-1:0] base_d [BASELINE_SECONDS];
  logic [BIDX_W-1:0]      bidx_q,     bidx_d;
  logic                   compare_q,  compare_d;
  logic                   lux_seen_q, lux_seen_d;
  logic                   night_q,    night_d;
  logic                   sound_q,    sound_d;
  logic [ON_TICKS_W-1:0]  lcnt_q,     lcnt_d;
  logic                   lamp_q,     lamp_d;

  // Baseline products against the rise setting of the coming cycle; a second ends
  // at most once every SAMPLES_PER_SECOND items, so the register between the
  // baseline and these products never matters.
  logic [RHS_W-1:0]       rhs_q [BASELINE_SECONDS];
  logic [FACTOR_W-1:0]    factor;

  assign factor = FACTOR_W'(PCT_SCALE) + FACTOR_W'(rise_d);

  always_ff @(posedge clk_i) begin
    for (int k = 0; k < BASELINE_SECONDS; k++) begin
      rhs_q[k] <= RHS_W'(base_q[k]) * RHS_W'(factor);
    end
  end

  // End-of-second datapath
  logic [SUM_W-1:0]       sum_add;
  logic                   sec_done;
  logic [SAMPLE_BITS-1:0] avg;
  logic [RHS_W-1:0]       lhs;
  logic                   rise_hit;
  logic                   dark;

  assign sum_add  = sum_q + SUM_W'(mic_q);
  assign sec_done = (scnt_q == SCNT_W'(SAMPLES_PER_SECOND - 1));
  assign avg      = sps_div(sum_add);
  assign lhs      = RHS_W'(avg) * RHS_W'(PCT_SCALE);
  assign dark     = (lux_q < dark_thr_q);

  always_comb begin
    rise_hit = 1'b0;
    for (int k = 0; k < BASELINE_SECONDS; k++) begin
      if (lhs > rhs_q[k]) rise_hit = 1'b1;
    end
  end

  always_comb begin
    sum_d      = sum_q;
    scnt_d     = scnt_q;
    base_d     = base_q;
    bidx_d     = bidx_q;
    compare_d  = compare_q;
    lux_seen_d = lux_seen_q;
    night_d    = night_q;
    sound_d    = sound_q;
    lcnt_d     = lcnt_q;
    lamp_d     = lamp_q;

    unique case (op_q)
      OP_MIC: begin
        if (!sec_done) begin
          sum_d  = sum_add;
          scnt_d = scnt_q + SCNT_W'(1);
        end else begin
          // Close the second: restart the sum, then fill or compare-and-shift
          sum_d  = '0;
          scnt_d = '0;
          if (!compare_q) begin
            base_d[bidx_q] = avg;
            if (bidx_q == BIDX_W'(BASELINE_SECONDS - 1)) begin
              compare_d = 1'b1;
            end else begin
              bidx_d = bidx_q + BIDX_W'(1);
            end
          end else begin
            if (rise_hit) sound_d = 1'b1;
            for (int k = 0; k < BASELINE_SECONDS - 1; k++) begin
              base_d[k] = base_q[k+1];
            end
            base_d[BASELINE_SECONDS-1] = avg;
          end
        end
      end
      OP_LUX: begin
        // First reading decides outright; later ones only switch night mode on
        if (!lux_seen_q) begin
          night_d    = dark;
          lux_seen_d = 1'b1;
        end else if (dark && sound_q) begin
          night_d = 1'b1;
        end
      end
      OP_TICK: begin
        if (night_q) begin
          if (lcnt_q < on_ticks_q) begin
            lamp_d = 1'b1;
            lcnt_d = lcnt_q + ON_TICKS_W'(1);
          end else begin
            lamp_d  = 1'b0;
            sound_d = 1'b0;
            night_d = 1'b0;
            lcnt_d  = '0;
          end
        end
      end
      OP_BUTTON: begin
        night_d = 1'b1;
        lcnt_d  = '0;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sum_q      <= '0;
      scnt_q     <= '0;
      for (int k = 0; k < BASELINE_SECONDS; k++) base_q[k] <= '0;
      bidx_q     <= '0;
      compare_q  <= 1'b0;
      lux_seen_q <= 1'b0;
      night_q    <= 1'b0;
      sound_q    <= 1'b0;
      lcnt_q     <= '0;
      lamp_q     <= 1'b0;
    end else if (advance) begin
      sum_q      <= sum_d;
      scnt_q     <= scnt_d;
      base_q     <= base_d;
      bidx_q     <= bidx_d;
      compare_q  <= compare_d;
      lux_seen_q <= lux_seen_d;
      night_q    <= night_d;
      sound_q    <= sound_d;
      lcnt_q     <= lcnt_d;
      lamp_q     <= lamp_d;
    end
  end

  // Result register
  logic lamp_out_q, night_out_q, sound_out_q, mon_out_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      lamp_out_q  <= lamp_d;
      night_out_q <= night_d;
      sound_out_q <= sound_d;
      mon_out_q   <= compare_d;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign lamp_on_o      = lamp_out_q;
  assign night_active_o = night_out_q;
  assign sound_seen_o   = sound_out_q;
  assign monitoring_o   = mon_out_q;

  // Assertions
  a_scnt_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    scnt_q < SCNT_W'(SAMPLES_PER_SECOND))
    else $error("sample count past one second");

  a_compare_sticky: assert property (@(posedge clk_i) disable iff (!rst_ni)
    compare_q |=> compare_q)
    else $error("monitoring phase dropped");

  a_sound_source: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!sound_q ##1 sound_q) |-> $past(advance && op_q == OP_MIC && sec_done && compare_q))
    else $error("sound flag set outside a compared second");

  a_result_follows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_q && !out_valid_q) |=> out_valid_q)
    else $error("held item not moved to result register");

endmodule
